// ===== src/psl_pkg.sv =====
package psl_pkg;

    // Default parameter values
    localparam int DATA_WIDTH_DEF = 16;
    localparam int GAIN_FRAC_DEF  = 12;

    // Fixed field widths
    localparam int GAIN_W   = 16;
    localparam int INT_W    = 14;
    localparam int DRIVE_W  = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int QUOT_W   = 16;

    // Integral clamp and percent scale
    localparam int INT_LIMIT     = 5000;
    localparam int PERCENT_SCALE = 100;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST     = 16'd2499;
    localparam logic [GAIN_W-1:0] GAIN_I_RST     = 16'd41;
    localparam logic [GAIN_W-1:0] GAIN_D_RST     = 16'd819;
    localparam logic [GAIN_W-1:0] FULL_SCALE_RST = 16'd430;

    // Register indexes
    localparam logic [1:0] REG_GAIN_P     = 2'd0;
    localparam logic [1:0] REG_GAIN_I     = 2'd1;
    localparam logic [1:0] REG_GAIN_D     = 2'd2;
    localparam logic [1:0] REG_FULL_SCALE = 2'd3;

    // Configuration set seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [GAIN_W-1:0] full_scale;
    } cfg_t;

    // Result of the scaling divider
    typedef struct packed {
        logic               saturated;
        logic [DRIVE_W-1:0] drive;
    } res_t;

    // Controller sequencing
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_UPD,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int byte_round(input int w);
        return ((w + 7) / 8) * 8;
    endfunction

endpackage

// ===== src/positional_pid_speed_loop.sv =====
// Positional PID speed loop with integral clamp. One input item is one control
// period (set_value, actual_value); one result item (drive, saturated) follows
// it. After acceptance the item passes through error, integral update, the
// gain multiply (one gain bit per cycle), magnitude, the x100 scaling and the
// scaling divide (one quotient bit per cycle) before the result is offered.
// A new item is taken once the previous one has reached the output register.
// Gains and the full scale are written over the APB port; the user must write
// them only while the block is idle, the block itself does not enforce this.
module positional_pid_speed_loop #(
    parameter int DATA_WIDTH     = psl_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = psl_pkg::GAIN_FRAC_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    // slave side
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // tdata: set_value, actual_value (from bit 0 up), zero padded to bytes
    input  logic [psl_pkg::byte_round(2*DATA_WIDTH)-1:0]   s_tdata,
    // master side
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // tdata: drive
    output logic [psl_pkg::DRIVE_W-1:0]                    m_tdata,
    // tuser: saturated
    output logic [0:0]                                     m_tuser,
    // configuration
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [psl_pkg::APB_AW-1:0]                     paddr,
    input  logic [psl_pkg::APB_DW-1:0]                     pwdata,
    output logic [psl_pkg::APB_DW-1:0]                     prdata,
    output logic                                           pready
);
    import psl_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int EW  = DW + 1;
    localparam int DFW = DW + 2;
    localparam int MW  = imax(DFW, INT_W);
    localparam int SW  = imax(EW, INT_W) + 1;
    localparam int AW  = MW + GAIN_W + 2;

    localparam logic signed [SW-1:0] LIM_HI = SW'(INT_LIMIT);
    localparam logic signed [SW-1:0] LIM_LO = -SW'(INT_LIMIT);

    state_t state_reg, state_next;

    cfg_t cfg;
    res_t div_res;

    logic signed [DW-1:0]    sp_reg, act_reg, last_sp_reg;
    logic signed [EW-1:0]    err_reg, prev_reg;
    logic signed [DFW-1:0]   dif_reg;
    logic signed [INT_W-1:0] sum_reg;
    logic signed [SW-1:0]    sum_raw;
    logic signed [INT_W-1:0] sum_clamped;

    logic                    m_tvalid_reg;
    logic [DRIVE_W-1:0]      drive_reg;
    logic                    sat_reg;

    logic                    accept;
    logic                    mac_start, mac_done;
    logic                    div_start, div_done;
    logic                    out_load;
    logic signed [AW-1:0]    mac_acc;

    // Configuration registers
    psl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Bit-serial gain multiply-accumulate
    psl_mac #(
        .MW (MW),
        .AW (AW)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .gain_p (cfg.gain_p),
        .gain_i (cfg.gain_i),
        .gain_d (cfg.gain_d),
        .op_p   (MW'(err_reg)),
        .op_i   (MW'(sum_reg)),
        .op_d   (MW'(dif_reg)),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    // Percent scaling and serial divide
    psl_div #(
        .AW             (AW),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .acc        (mac_acc),
        .full_scale (cfg.full_scale),
        .done       (div_done),
        .res        (div_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_ERR;
            ST_ERR:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_MAC;
            ST_MAC:  if (mac_done) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        mac_start = (state_reg == ST_UPD);
        div_start = (state_reg == ST_MAC) && mac_done;
        out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    assign accept = s_tvalid && s_tready;

    // Integral accumulate and clamp
    always_comb
    begin
        sum_raw = SW'(sum_reg) + SW'(err_reg);
        if (sum_raw >= LIM_HI)
        begin
            sum_clamped = INT_W'(LIM_HI);
        end
        else if (sum_raw <= LIM_LO)
        begin
            sum_clamped = INT_W'(LIM_LO);
        end
        else
        begin
            sum_clamped = INT_W'(sum_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Controller state: previous error, integral, last setpoint
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            sum_reg     <= '0;
            last_sp_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            prev_reg <= err_reg;
            if (sp_reg != last_sp_reg)
            begin
                last_sp_reg <= sp_reg;
                sum_reg     <= '0;
            end
            else
            begin
                sum_reg <= sum_clamped;
            end
        end
    end

    // Capture the item, form error and derivative difference
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sp_reg  <= s_tdata[DW-1:0];
            act_reg <= s_tdata[2*DW-1:DW];
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= EW'(sp_reg) - EW'(act_reg);
        end
        if (state_reg == ST_UPD)
        begin
            dif_reg <= DFW'(prev_reg) - DFW'(err_reg);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_reg <= div_res.drive;
            sat_reg   <= div_res.saturated;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = sat_reg;

endmodule

// ===== src/psl_regs.sv =====
module psl_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psl_pkg::APB_AW-1:0]   paddr,
    input  logic [psl_pkg::APB_DW-1:0]   pwdata,
    output logic [psl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output psl_pkg::cfg_t                cfg
);
    import psl_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    // Write the addressed register, keep the low half-word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= GAIN_P_RST;
            cfg_reg.gain_i     <= GAIN_I_RST;
            cfg_reg.gain_d     <= GAIN_D_RST;
            cfg_reg.full_scale <= FULL_SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_P:     cfg_reg.gain_p     <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:     cfg_reg.gain_i     <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:     cfg_reg.gain_d     <= pwdata[GAIN_W-1:0];
                REG_FULL_SCALE: cfg_reg.full_scale <= pwdata[GAIN_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            REG_GAIN_P:     prdata = APB_DW'(cfg_reg.gain_p);
            REG_GAIN_I:     prdata = APB_DW'(cfg_reg.gain_i);
            REG_GAIN_D:     prdata = APB_DW'(cfg_reg.gain_d);
            REG_FULL_SCALE: prdata = APB_DW'(cfg_reg.full_scale);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== src/psl_mac.sv =====
module psl_mac #(
    parameter int MW = 18,
    parameter int AW = 36
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [psl_pkg::GAIN_W-1:0]      gain_p,
    input  logic [psl_pkg::GAIN_W-1:0]      gain_i,
    input  logic [psl_pkg::GAIN_W-1:0]      gain_d,
    input  logic signed [MW-1:0]            op_p,
    input  logic signed [MW-1:0]            op_i,
    input  logic signed [MW-1:0]            op_d,
    output logic signed [AW-1:0]            acc,
    output logic                            done
);
    import psl_pkg::*;

    localparam int TW = MW + 2;
    localparam int CNTW = $clog2(GAIN_W + 1);

    logic [GAIN_W-1:0]     gp_reg, gi_reg, gd_reg;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic signed [TW-1:0]  term;
    logic [CNTW-1:0]       cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    assign acc  = acc_reg;
    assign done = done_reg;

    // Sum the operands selected by the current gain bits, MSB first
    always_comb
    begin
        term = (gp_reg[GAIN_W-1] ? TW'(op_p) : TW'(0))
             + (gi_reg[GAIN_W-1] ? TW'(op_i) : TW'(0))
             + (gd_reg[GAIN_W-1] ? TW'(op_d) : TW'(0));
        acc_next = (acc_reg <<< 1) + AW'(term);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(GAIN_W);
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNTW'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Load gains on start, then shift one bit of each gain per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            gp_reg  <= gain_p;
            gi_reg  <= gain_i;
            gd_reg  <= gain_d;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            gp_reg  <= gp_reg << 1;
            gi_reg  <= gi_reg << 1;
            gd_reg  <= gd_reg << 1;
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== src/psl_div.sv =====
module psl_div #(
    parameter int AW = 36,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [AW-1:0]          acc,
    input  logic [psl_pkg::GAIN_W-1:0]    full_scale,
    output logic                          done,
    output psl_pkg::res_t                 res
);
    import psl_pkg::*;

    localparam int PW = AW + 7;
    localparam int NW = PW - GAIN_FRAC_BITS;
    localparam int CW = imax(NW, 2 * QUOT_W);

    localparam logic [4:0] STEP_X96  = 5'd1;
    localparam logic [4:0] STEP_X100 = 5'd2;
    localparam logic [4:0] STEP_CHK  = 5'd3;
    localparam logic [4:0] STEP_DIV0 = 5'd4;
    localparam logic [4:0] STEP_LAST = 5'(4 + QUOT_W - 1);

    logic                 neg_reg;
    logic [AW-1:0]        mag_reg;
    logic [PW-1:0]        p_reg;
    logic                 ovf_reg;
    logic [QUOT_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic [4:0]           step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [GAIN_W-1:0]    msx;
    logic [NW-1:0]        n_val;
    logic [CW-1:0]        n_ext;
    logic [CW-1:0]        lim;
    logic [QUOT_W:0]      trial;
    logic                 ge;

    assign done = done_reg;

    // Divisor never zero; saturation bound is the divisor * 32769
    always_comb
    begin
        msx   = (full_scale == '0) ? GAIN_W'(1) : full_scale;
        n_val = NW'(p_reg >> GAIN_FRAC_BITS);
        n_ext = CW'(n_val);
        lim   = CW'({msx, 15'b0}) + CW'(msx);
        trial = {rem_reg, q_reg[QUOT_W-1]};
        ge    = trial >= {1'b0, msx};
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_X96;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_LAST);
            if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Magnitude, scale by one hundred, range check, then restoring divide
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= acc[AW-1];
            mag_reg <= acc[AW-1] ? AW'(-acc) : AW'(acc);
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_X96:
                begin
                    p_reg <= (PW'(mag_reg) << 6) + (PW'(mag_reg) << 5);
                end
                STEP_X100:
                begin
                    p_reg <= p_reg + (PW'(mag_reg) << 2);
                end
                STEP_CHK:
                begin
                    ovf_reg <= n_ext >= lim;
                    rem_reg <= n_ext[2*QUOT_W-1:QUOT_W];
                    q_reg   <= n_ext[QUOT_W-1:0];
                end
                default:
                begin
                    if (step_reg >= STEP_DIV0)
                    begin
                        rem_reg <= ge ? QUOT_W'(trial - {1'b0, msx}) : trial[QUOT_W-1:0];
                        q_reg   <= {q_reg[QUOT_W-2:0], ge};
                    end
                end
            endcase
        end
    end

    // Sign and saturate the quotient
    always_comb
    begin
        if (ovf_reg)
        begin
            res.saturated = 1'b1;
            res.drive     = neg_reg ? 16'h8000 : 16'h7FFF;
        end
        else if (!neg_reg && q_reg[QUOT_W-1])
        begin
            res.saturated = 1'b1;
            res.drive     = 16'h7FFF;
        end
        else
        begin
            res.saturated = 1'b0;
            res.drive     = neg_reg ? DRIVE_W'(-q_reg) : DRIVE_W'(q_reg);
        end
    end

endmodule

// ===== src/psl_chk.sv =====
module psl_chk (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [15:0]                            m_tdata,
    input logic [0:0]                             m_tuser
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The block works on one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in work");

    // A saturated result sits at one end of the range
    a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7FFF || m_tdata == 16'h8000))
        else $error("saturated result not at range end");

endmodule

bind positional_pid_speed_loop psl_chk u_chk (.*);
